>>> hdl/bpdq_pkg.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// bpdq_pkg
// Shared types and constants for the button press-duration qualifier.
// -----------------------------------------------------------------------------
package bpdq_pkg;

   localparam int NUM_BUTTONS_DEFAULT = 7;
   localparam int COUNT_WIDTH_DEFAULT = 16;
   localparam int THRESHOLD_WIDTH     = 16;
   localparam int OP_WIDTH            = 2;
   localparam int RSP_DATA_WIDTH      = 8;

   typedef enum logic [OP_WIDTH-1:0] {
      OP_TICK  = 2'd0,
      OP_CLICK = 2'd1,
      OP_HOLD  = 2'd2
   } op_type;

   // per-lane update strobes
   typedef struct packed {
      logic tick;
      logic clear;
   } lane_ctl_type;

   // merged outcome of one item
   typedef struct packed {
      logic hit;
      logic wake;
      logic clear;
   } merge_res_type;

   // one result word
   typedef struct packed {
      logic wake;
      logic hit;
   } rsp_type;

endpackage

>>> hdl/bpdq_lane.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// bpdq_lane
// Press-duration counter and last-level bit of one button.
// -----------------------------------------------------------------------------
module bpdq_lane
   import bpdq_pkg::*;
#(
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  lane_ctl_type           ctl,
   input  logic                   level,
   output logic [COUNT_WIDTH-1:0] count
);

   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic                   was_ff, was_in;
   logic [COUNT_WIDTH-1:0] base;

   always_comb begin
      count_in = count_ff;
      was_in   = was_ff;
      // a fresh press restarts from zero before the increment
      base     = was_ff ? count_ff : '0;
      if (ctl.tick) begin
         was_in = level;
         if (level) begin
            count_in = (&base) ? base : base + 1'b1;
         end
      end else if (ctl.clear) begin
         count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         was_ff   <= 1'b0;
      end else begin
         count_ff <= count_in;
         was_ff   <= was_in;
      end
   end

   assign count = count_ff;

endmodule

>>> hdl/bpdq_merge.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// bpdq_merge
// Combines the lane counts: wake flag for ticks, threshold compare for queries.
// -----------------------------------------------------------------------------
module bpdq_merge
   import bpdq_pkg::*;
#(
   parameter int NUM_BUTTONS = NUM_BUTTONS_DEFAULT,
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT,
   parameter int INDEX_WIDTH = $clog2(NUM_BUTTONS + 1)
) (
   input  op_type                                  op,
   input  logic [NUM_BUTTONS-1:0]                  pressed_mask,
   input  logic [INDEX_WIDTH-1:0]                  button_index,
   input  logic [THRESHOLD_WIDTH-1:0]              threshold,
   input  logic [NUM_BUTTONS-1:0][COUNT_WIDTH-1:0] counts,
   output merge_res_type                           res
);

   localparam int CMP_WIDTH = (COUNT_WIDTH > THRESHOLD_WIDTH) ? COUNT_WIDTH
                                                               : THRESHOLD_WIDTH;

   logic [COUNT_WIDTH-1:0] sel_count;
   logic                   sel_level;
   logic                   in_range;
   logic                   met;

   // one-hot select of the asked lane; out-of-range index selects nothing
   always_comb begin
      sel_count = '0;
      sel_level = 1'b0;
      in_range  = 1'b0;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
         if (button_index == INDEX_WIDTH'(i)) begin
            sel_count = counts[i];
            sel_level = pressed_mask[i];
            in_range  = 1'b1;
         end
      end
   end

   assign met = CMP_WIDTH'(sel_count) >= CMP_WIDTH'(threshold);

   always_comb begin
      res = '0;
      unique case (op)
         OP_TICK:  res.wake = |pressed_mask;
         OP_CLICK: begin
            res.hit   = in_range && met && !sel_level;
            res.clear = in_range && met && !sel_level;
         end
         OP_HOLD:  res.hit = in_range && met && sel_level;
         default:  res = '0;
      endcase
   end

endmodule

>>> hdl/button_press_duration_qualifier.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// button_press_duration_qualifier
// Per-button press timing with click and hold queries.
// -----------------------------------------------------------------------------
// usage:
//   req channel: tuser carries the op (tick, click query, hold query), tdata
//   the pressed levels, the queried button and the threshold. Every accepted
//   word gives exactly one rsp word: hit for queries, wake for ticks.
//   result: registered in the output register, or in the skid register on a stall.
//   throughput: one word per cycle while req_tready is high; one lane per
//   button updates in parallel and a merge stage does the index select and one threshold compare.
//   stall: a two-entry output buffer (output register plus skid register)
//   lets one more word in while a result waits; req_tready drops only when
//   both entries are full, so no result is ever lost or repeated.
//   reset: all counts and last levels clear to released, the buffer empties.
//   an unused op, or a query with an out-of-range button index, gives hit 0
//   and wake 0 and leaves the state untouched.
// -----------------------------------------------------------------------------
module button_press_duration_qualifier
   import bpdq_pkg::*;
#(
   parameter int NUM_BUTTONS = NUM_BUTTONS_DEFAULT,
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT,
   parameter int INDEX_WIDTH = $clog2(NUM_BUTTONS + 1),
   parameter int REQ_DATA_WIDTH =
      ((NUM_BUTTONS + INDEX_WIDTH + THRESHOLD_WIDTH + 7) / 8) * 8
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // pressed_mask, button_index, threshold, zero fill
   input  logic [REQ_DATA_WIDTH-1:0] req_tdata,
   // op
   input  logic [OP_WIDTH-1:0]       req_tuser,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // hit, wake, zero fill
   output logic [RSP_DATA_WIDTH-1:0] rsp_tdata
);

   logic [NUM_BUTTONS-1:0]                  pressed_mask;
   logic [INDEX_WIDTH-1:0]                  button_index;
   logic [THRESHOLD_WIDTH-1:0]              threshold;
   op_type                                  op;
   logic                                    accept;
   logic [NUM_BUTTONS-1:0][COUNT_WIDTH-1:0] counts;
   lane_ctl_type [NUM_BUTTONS-1:0]          lane_ctl;
   merge_res_type                           res;
   rsp_type                                 res_word;

   logic    out_vld_ff, out_vld_in;
   logic    skid_vld_ff, skid_vld_in;
   rsp_type out_ff, out_in;
   rsp_type skid_ff, skid_in;
   logic    out_take;

   assign pressed_mask = req_tdata[NUM_BUTTONS-1:0];
   assign button_index = req_tdata[NUM_BUTTONS +: INDEX_WIDTH];
   assign threshold    = req_tdata[NUM_BUTTONS + INDEX_WIDTH +: THRESHOLD_WIDTH];
   assign op           = op_type'(req_tuser);

   assign req_tready = !skid_vld_ff;
   assign accept     = req_tvalid && req_tready;

   for (genvar g = 0; g < NUM_BUTTONS; g++) begin : g_lane
      assign lane_ctl[g].tick  = accept && (op == OP_TICK);
      assign lane_ctl[g].clear = accept && res.clear &&
                                 (button_index == INDEX_WIDTH'(g));

      bpdq_lane #(
         .COUNT_WIDTH (COUNT_WIDTH)
      ) u_lane (
         .clock (clock),
         .reset (reset),
         .ctl   (lane_ctl[g]),
         .level (pressed_mask[g]),
         .count (counts[g])
      );
   end

   bpdq_merge #(
      .NUM_BUTTONS (NUM_BUTTONS),
      .COUNT_WIDTH (COUNT_WIDTH),
      .INDEX_WIDTH (INDEX_WIDTH)
   ) u_merge (
      .op           (op),
      .pressed_mask (pressed_mask),
      .button_index (button_index),
      .threshold    (threshold),
      .counts       (counts),
      .res          (res)
   );

   assign res_word.hit  = res.hit;
   assign res_word.wake = res.wake;
   assign out_take      = out_vld_ff && rsp_tready;

   // output register with skid entry behind it
   always_comb begin
      out_vld_in  = out_vld_ff;
      skid_vld_in = skid_vld_ff;
      out_in      = out_ff;
      skid_in     = skid_ff;
      if (!out_vld_ff || out_take) begin
         if (skid_vld_ff) begin
            out_in      = skid_ff;
            out_vld_in  = 1'b1;
            skid_vld_in = 1'b0;
         end else if (accept) begin
            out_in     = res_word;
            out_vld_in = 1'b1;
         end else begin
            out_vld_in = 1'b0;
         end
      end else if (accept) begin
         skid_in     = res_word;
         skid_vld_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         out_vld_ff  <= out_vld_in;
         skid_vld_ff <= skid_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {{(RSP_DATA_WIDTH - 2){1'b0}}, out_ff.wake, out_ff.hit};

   // the skid entry is only ever filled behind a full output register
   a_skid_behind_out : assert property (
      @(posedge clock) disable iff (reset) skid_vld_ff |-> out_vld_ff
   ) else $error("skid entry valid with empty output register");

   // a word taken while the output stalls lands in the skid entry
   a_stall_to_skid : assert property (
      @(posedge clock) disable iff (reset)
      (accept && out_vld_ff && !rsp_tready) |=> skid_vld_ff
   ) else $error("stalled result not parked in skid entry");

   // a result never carries both a query hit and a tick wake
   a_hit_wake_excl : assert property (
      @(posedge clock) disable iff (reset) !(res.hit && res.wake)
   ) else $error("hit and wake raised together");

   // a count clear only comes from a click query
   a_clear_on_click : assert property (
      @(posedge clock) disable iff (reset) res.clear |-> (op == OP_CLICK)
   ) else $error("count clear outside a click query");

endmodule
